// ----- rtl/core/rgbds_pkg.sv -----
// Shared types and constants for the 2x2 box downscaler.
`timescale 1ns / 1ps

package rgbds_pkg;

   localparam int CHAN_W     = 8;
   localparam int PAIR_W     = CHAN_W + 1;
   localparam int QUAD_W     = CHAN_W + 2;
   localparam int CFG_W      = 13;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int MIN_SIZE   = 2;

   // register index, taken from address bit 2
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
   localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [PAIR_W-1:0] red;
      logic [PAIR_W-1:0] green;
      logic [PAIR_W-1:0] blue;
   } pair_sum_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } line_cmd_type;

endpackage

// ----- rtl/core/rgbds_line_mem.sv -----
// Line store of horizontal pair sums: one synchronous port, registered read.
`timescale 1ns / 1ps

module rgbds_line_mem #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  logic                  clock,
   input  rgbds_pkg::line_cmd_type cmd,
   input  logic [ADDR_W-1:0]     addr,
   input  rgbds_pkg::pair_sum_type wr_data,
   output rgbds_pkg::pair_sum_type rd_data
);
   import rgbds_pkg::*;

   pair_sum_type pair_line_ff [DEPTH];
   pair_sum_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         pair_line_ff[addr] <= wr_data;
      end
   end

   // hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= pair_line_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/rgb_half_downscale_box2x2.sv -----
// 2x2 box-filter half-size downscaler for RGB888 raster frames, BGR output.
//
// Usage: source pixels enter on the req_ channel in raster order, one per
// transaction. Each 2x2 block gives one averaged pixel on the rsp_ channel
// (blue, green, red), sent after the block's lower-right pixel is taken;
// rsp_frame_last marks the final output pixel of the frame. An odd last
// column or row is consumed with no output. The user must write frame_width
// and frame_height (CSR offsets 0x0 and 0x4) only between frames, with no
// pixel in flight; the block itself does not enforce this.
// Throughput: one pixel per clock while req_stall is low. Each pixel makes at most one access to
// the pair-sum line store (write on even rows, read on odd rows), and that
// single port sets the rate.
// A result moves through the read stage and the output register. When the
// receiver stalls, the output register holds and one more result waits in the
// read stage; after that req_stall rises until rsp_stall falls.
// Reset clears the position to the frame origin and the sizes to 640x480;
// no pixel is taken while reset is high. The line store is not cleared.
`timescale 1ns / 1ps

module rgb_half_downscale_box2x2 #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rgbds_pkg::CHAN_W-1:0]     req_in_red,
   input  logic [rgbds_pkg::CHAN_W-1:0]     req_in_green,
   input  logic [rgbds_pkg::CHAN_W-1:0]     req_in_blue,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rgbds_pkg::CHAN_W-1:0]     rsp_out_first,
   output logic [rgbds_pkg::CHAN_W-1:0]     rsp_out_second,
   output logic [rgbds_pkg::CHAN_W-1:0]     rsp_out_third,
   output logic                             rsp_frame_last,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rgbds_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rgbds_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rgbds_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import rgbds_pkg::*;

   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int RW         = $clog2(MAX_HEIGHT);
   localparam int HW         = $clog2(MAX_HEIGHT + 1);
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int IW         = $clog2(LINE_DEPTH);

   function automatic int clamp_size(logic [CFG_W-1:0] v, int hi);
      int s;
      s = int'(v);
      if (s < MIN_SIZE) begin
         s = MIN_SIZE;
      end else if (s > hi) begin
         s = hi;
      end
      return s;
   endfunction

   // ---------------- configuration ----------------
   logic [CFG_W-1:0] frame_width_ff, frame_height_ff;
   logic [WW-1:0]    width_ff, width_in;
   logic [HW-1:0]    height_ff, height_in;
   logic [CW-1:0]    last_col_ff, last_col_in;
   logic [RW-1:0]    last_row_ff, last_row_in;
   logic [CFG_W-1:0] reset_w_raw, reset_h_raw;
   logic [WW-1:0]    reset_width;
   logic [HW-1:0]    reset_height;
   logic [CW-1:0]    reset_last_col;
   logic [RW-1:0]    reset_last_row;
   logic             csr_write;
   logic [CFG_W-1:0] wr_value;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wr_value   = csr_pwdata[CFG_W-1:0];

   always_comb begin
      int wc;
      int hc;
      wc = clamp_size(wr_value, MAX_WIDTH);
      hc = clamp_size(wr_value, MAX_HEIGHT);
      width_in    = WW'(wc);
      height_in   = HW'(hc);
      last_col_in = CW'((wc & ~1) - 1);
      last_row_in = RW'((hc & ~1) - 1);
   end

   always_comb begin
      int wr;
      int hr;
      wr = clamp_size(RESET_FRAME_WIDTH, MAX_WIDTH);
      hr = clamp_size(RESET_FRAME_HEIGHT, MAX_HEIGHT);
      reset_w_raw    = RESET_FRAME_WIDTH;
      reset_h_raw    = RESET_FRAME_HEIGHT;
      reset_width    = WW'(wr);
      reset_height   = HW'(hr);
      reset_last_col = CW'((wr & ~1) - 1);
      reset_last_row = RW'((hr & ~1) - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= reset_w_raw;
         frame_height_ff <= reset_h_raw;
         width_ff        <= reset_width;
         height_ff       <= reset_height;
         last_col_ff     <= reset_last_col;
         last_row_ff     <= reset_last_row;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_FRAME_WIDTH: begin
               frame_width_ff <= wr_value;
               width_ff       <= width_in;
               last_col_ff    <= last_col_in;
            end
            REG_FRAME_HEIGHT: begin
               frame_height_ff <= wr_value;
               height_ff       <= height_in;
               last_row_ff     <= last_row_in;
            end
            default: begin
               frame_width_ff <= frame_width_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- accept stage ----------------
   logic         s1_valid_ff, s1_valid_in;
   pair_sum_type s1_pair_ff;
   logic         s1_last_ff;
   logic         s1_move;
   logic         req_accept;
   logic         rsp_valid_ff, rsp_valid_in;

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = reset || (s1_valid_ff && !s1_move);
   assign req_accept = req_valid && !req_stall;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW:0]   col_inc;
   logic [RW:0]   row_inc;
   logic          col_wrap;
   pixel_type     left_ff;
   pixel_type     pix;
   pair_sum_type  pair;
   line_cmd_type  line_cmd;
   pair_sum_type  line_rd;
   logic          at_last;

   assign pix = '{red: req_in_red, green: req_in_green, blue: req_in_blue};

   assign col_inc  = {1'b0, col_ff} + 1'b1;
   assign row_inc  = {1'b0, row_ff} + 1'b1;
   assign col_wrap = col_inc >= (CW + 1)'(width_ff);

   always_comb begin
      col_in = col_wrap ? '0 : col_inc[CW-1:0];
      row_in = row_ff;
      if (col_wrap) begin
         row_in = (row_inc >= (RW + 1)'(height_ff)) ? '0 : row_inc[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (!col_ff[0]) begin
            left_ff <= pix;
         end
      end
   end

   assign pair.red   = {1'b0, left_ff.red}   + {1'b0, pix.red};
   assign pair.green = {1'b0, left_ff.green} + {1'b0, pix.green};
   assign pair.blue  = {1'b0, left_ff.blue}  + {1'b0, pix.blue};

   // even rows store the pair sum, odd rows fetch it; a row always lies
   // between the write and the read of one entry, so no forwarding is needed
   assign line_cmd.wr_en = req_accept && col_ff[0] && !row_ff[0];
   assign line_cmd.rd_en = req_accept && col_ff[0] && row_ff[0];
   assign at_last        = (col_ff == last_col_ff) && (row_ff == last_row_ff);

   rgbds_line_mem #(
      .DEPTH  (LINE_DEPTH),
      .ADDR_W (IW)
   ) u_line_mem (
      .clock   (clock),
      .cmd     (line_cmd),
      .addr    (col_ff[IW:1]),
      .wr_data (pair),
      .rd_data (line_rd)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (line_cmd.rd_en) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (line_cmd.rd_en) begin
         s1_pair_ff <= pair;
         s1_last_ff <= at_last;
      end
   end

   // ---------------- output register ----------------
   logic [QUAD_W-1:0] quad_red, quad_green, quad_blue;
   logic [CHAN_W-1:0] out_first_ff, out_second_ff, out_third_ff;
   logic              out_last_ff;

   assign quad_red   = {1'b0, line_rd.red}   + {1'b0, s1_pair_ff.red};
   assign quad_green = {1'b0, line_rd.green} + {1'b0, s1_pair_ff.green};
   assign quad_blue  = {1'b0, line_rd.blue}  + {1'b0, s1_pair_ff.blue};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_first_ff  <= quad_blue[QUAD_W-1:2];
         out_second_ff <= quad_green[QUAD_W-1:2];
         out_third_ff  <= quad_red[QUAD_W-1:2];
         out_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_first  = out_first_ff;
   assign rsp_out_second = out_second_ff;
   assign rsp_out_third  = out_third_ff;
   assign rsp_frame_last = out_last_ff;

   // ---------------- assertions ----------------
   a_line_one_access: assert property (@(posedge clock) disable iff (reset)
      !(line_cmd.wr_en && line_cmd.rd_en))
      else $error("line store written and read in one cycle");

   a_fetch_fills_s1: assert property (@(posedge clock) disable iff (reset)
      line_cmd.rd_en |=> s1_valid_ff)
      else $error("odd-row fetch did not enter the read stage");

   a_full_pipe_stalls: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("pixel taken while both stages are held");

   a_width_clamped: assert property (@(posedge clock) disable iff (reset)
      (width_ff >= WW'(MIN_SIZE)) && ((CW + 1)'(width_ff) <= (CW + 1)'(MAX_WIDTH)))
      else $error("working width outside its range");

   a_move_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("read stage moved without filling the output register");

endmodule

// ----- dv/rgb_half_downscale_box2x2_test.sv -----
// Self-checking testbench for the 2x2 box downscaler: random raster frames, CSR sizes, stalls.
`timescale 1ns / 1ps

module rgb_half_downscale_box2x2_test;
   import rgbds_pkg::*;

   localparam int FRAME_MAX  = 4096;
   localparam int SETTLE_GAP = 8;
   localparam int PHASE_PIX  = 450;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
      logic              last;
   } box_avg_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CHAN_W-1:0]     req_in_red = '0;
   logic [CHAN_W-1:0]     req_in_green = '0;
   logic [CHAN_W-1:0]     req_in_blue = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CHAN_W-1:0]     rsp_out_first;
   logic [CHAN_W-1:0]     rsp_out_second;
   logic [CHAN_W-1:0]     rsp_out_third;
   logic                  rsp_frame_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // source pixels waiting to be sent, averages waiting to come out
   pixel_type   src_pixels[$];
   box_avg_type avg_due[$];

   // shadow of the downscaler state
   pair_sum_type pair_line [FRAME_MAX/2];
   pixel_type    left_px = '0;
   int unsigned  pos_col = 0;
   int unsigned  pos_row = 0;
   logic [CFG_W-1:0] cfg_width  = RESET_FRAME_WIDTH;
   logic [CFG_W-1:0] cfg_height = RESET_FRAME_HEIGHT;

   int send_idle_pct = 13;
   int recv_idle_pct = 80;
   bit send_burst = 1'b0;
   bit recv_burst = 1'b0;
   int fail_count = 0;
   int src_taken = 0;
   int avg_seen = 0;

   rgb_half_downscale_box2x2 #(
      .MAX_WIDTH (FRAME_MAX),
      .MAX_HEIGHT(FRAME_MAX)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_first (rsp_out_first),
      .rsp_out_second(rsp_out_second),
      .rsp_out_third (rsp_out_third),
      .rsp_frame_last(rsp_frame_last),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #2 clock = ~clock;

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > FRAME_MAX) return FRAME_MAX;
      return 32'(v);
   endfunction

   function automatic logic [CHAN_W-1:0] rand_chan();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Fold one source pixel into the shadow state; queue the average it completes.
   task automatic downscale_pixel(input pixel_type px);
      int unsigned w;
      int unsigned h;
      int unsigned idx;
      pair_sum_type pair;
      pair_sum_type above;
      logic [QUAD_W-1:0] sr, sg, sb;
      box_avg_type avg;
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      if (pos_col[0] == 1'b0) begin
         left_px = px;
      end else begin
         pair.red   = PAIR_W'(left_px.red) + px.red;
         pair.green = PAIR_W'(left_px.green) + px.green;
         pair.blue  = PAIR_W'(left_px.blue) + px.blue;
         idx = pos_col >> 1;
         if (pos_row[0] == 1'b0) begin
            pair_line[idx] = pair;
         end else begin
            above = pair_line[idx];
            sr = QUAD_W'(above.red) + pair.red;
            sg = QUAD_W'(above.green) + pair.green;
            sb = QUAD_W'(above.blue) + pair.blue;
            avg.red   = sr[QUAD_W-1:2];
            avg.green = sg[QUAD_W-1:2];
            avg.blue  = sb[QUAD_W-1:2];
            avg.last  = (pos_col == (w & ~32'd1) - 1) && (pos_row == (h & ~32'd1) - 1);
            avg_due.push_back(avg);
         end
      end
      pos_col++;
      if (pos_col >= w) begin
         pos_col = 0;
         pos_row++;
         if (pos_row >= h) pos_row = 0;
      end
   endtask

   // Source side: hold a stalled transaction, otherwise offer the next pixel or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            downscale_pixel(pixel_type'{req_in_red, req_in_green, req_in_blue});
            src_taken++;
         end
         if ($urandom_range(0, 49) == 0) send_burst = ~send_burst;
         if (!req_valid || !req_stall) begin
            if (src_pixels.size() != 0 &&
                (send_burst || $urandom_range(0, 99) >= send_idle_pct)) begin
               req_in_red   <= src_pixels[0].red;
               req_in_green <= src_pixels[0].green;
               req_in_blue  <= src_pixels[0].blue;
               void'(src_pixels.pop_front());
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ($urandom_range(0, 49) == 0) recv_burst = ~recv_burst;
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !recv_burst && ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Result side: compare each transaction with the oldest queued average.
   always @(posedge clock) begin
      box_avg_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         avg_seen++;
         if (avg_due.size() == 0) begin
            $error("unexpected output pixel B=%0d G=%0d R=%0d last=%0b",
                   rsp_out_first, rsp_out_second, rsp_out_third, rsp_frame_last);
            fail_count++;
         end else begin
            want = avg_due.pop_front();
            if (rsp_out_first !== want.blue) begin
               $error("out_first: expected %0d, got %0d", want.blue, rsp_out_first);
               fail_count++;
            end
            if (rsp_out_second !== want.green) begin
               $error("out_second: expected %0d, got %0d", want.green, rsp_out_second);
               fail_count++;
            end
            if (rsp_out_third !== want.red) begin
               $error("out_third: expected %0d, got %0d", want.red, rsp_out_third);
               fail_count++;
            end
            if (rsp_frame_last !== want.last) begin
               $error("frame_last: expected %0b, got %0b", want.last, rsp_frame_last);
               fail_count++;
            end
         end
      end
   end

   task automatic csr_xfer(input logic wr, input logic idx, input logic [CSR_DATA_W-1:0] wdata,
                           output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check(input logic idx, input logic [CFG_W-1:0] want);
      logic [CSR_DATA_W-1:0] rd;
      csr_xfer(1'b0, idx, '0, rd);
      if (rd !== CSR_DATA_W'(want)) begin
         $error("csr readback %0d: expected %0d, got %0d", idx, want, rd);
         fail_count++;
      end
   endtask

   // Upper data bits are junk; only the low 13 bits land in the register.
   task automatic csr_write(input logic idx, input logic [CFG_W-1:0] val);
      logic [CSR_DATA_W-1:0] rd;
      csr_xfer(1'b1, idx, ($urandom() & 32'hFFFF_E000) | CSR_DATA_W'(val), rd);
      if (idx == REG_FRAME_WIDTH) cfg_width = val;
      else cfg_height = val;
      csr_check(idx, val);
   endtask

   // Hold off until the pipe is empty and every queued average has come back.
   task automatic settle();
      do @(posedge clock); while (src_pixels.size() != 0 || req_valid || avg_due.size() != 0);
      repeat (SETTLE_GAP) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic push_frame(input bit pause_mid, inout int queued);
      int unsigned n;
      n = clamp_dim(cfg_width) * clamp_dim(cfg_height);
      @(negedge clock);
      for (int unsigned i = 0; i < n; i++) begin
         if (pause_mid && i == n / 2) settle();
         src_pixels.push_back(pixel_type'{rand_chan(), rand_chan(), rand_chan()});
      end
      queued += n;
   endtask

   initial begin
      int phase_pix;
      int nframes;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      csr_check(REG_FRAME_WIDTH, RESET_FRAME_WIDTH);
      csr_check(REG_FRAME_HEIGHT, RESET_FRAME_HEIGHT);

      // smallest frame: saturated, black, and rounding down
      csr_write(REG_FRAME_WIDTH, 13'd2);
      csr_write(REG_FRAME_HEIGHT, 13'd2);
      @(negedge clock);
      repeat (4) src_pixels.push_back(pixel_type'{8'hFF, 8'hFF, 8'hFF});
      repeat (4) src_pixels.push_back(pixel_type'{8'h00, 8'h00, 8'h00});
      src_pixels.push_back(pixel_type'{8'd1, 8'd2, 8'd3});
      src_pixels.push_back(pixel_type'{8'd0, 8'd0, 8'd0});
      src_pixels.push_back(pixel_type'{8'd0, 8'd0, 8'd0});
      src_pixels.push_back(pixel_type'{8'd2, 8'd1, 8'd0});
      settle();

      // odd width and height: trailing column and row give nothing
      csr_write(REG_FRAME_WIDTH, 13'd3);
      csr_write(REG_FRAME_HEIGHT, 13'd3);
      @(negedge clock);
      for (int i = 0; i < 9; i++)
         src_pixels.push_back(pixel_type'{8'(i * 31), 8'(255 - i * 29), 8'(i * 17 + 3)});
      settle();

      // sizes below the minimum clamp up to 2
      csr_write(REG_FRAME_WIDTH, 13'd1);
      csr_write(REG_FRAME_HEIGHT, 13'd0);
      @(negedge clock);
      src_pixels.push_back(pixel_type'{8'd255, 8'd0, 8'd128});
      src_pixels.push_back(pixel_type'{8'd254, 8'd1, 8'd127});
      src_pixels.push_back(pixel_type'{8'd255, 8'd3, 8'd128});
      src_pixels.push_back(pixel_type'{8'd255, 8'd2, 8'd127});
      settle();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 80 : 0;
         recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 13 : 0;
         phase_pix = 0;
         while (phase_pix < PHASE_PIX) begin
            if ($urandom_range(0, 3) != 0)
               csr_write(REG_FRAME_WIDTH, ($urandom_range(0, 99) < 85) ?
                         CFG_W'($urandom_range(0, 12)) : CFG_W'($urandom_range(13, 48)));
            if ($urandom_range(0, 3) != 0)
               csr_write(REG_FRAME_HEIGHT, ($urandom_range(0, 99) < 85) ?
                         CFG_W'($urandom_range(0, 9)) : CFG_W'($urandom_range(10, 20)));
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++)
               push_frame(phase_pix == 0 || $urandom_range(0, 7) == 0, phase_pix);
            settle();
         end
      end

      if (avg_due.size() != 0) begin
         $error("%0d output pixels never arrived", avg_due.size());
         fail_count++;
      end
      $display("Sent %0d source pixels and checked %0d averaged pixels over frame sizes",
               src_taken, avg_seen);
      $display("from the clamped 2x2 floor up to 48x20, odd sizes included, three stall mixes.");
      if (fail_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2_000_000;
      $error("timeout: pixels still pending or results missing");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
